// ===== src/key_click_event_detector_core_defines.svh =====
// assertion macros used by the core rtl file
`ifndef KEY_CLICK_EVENT_DETECTOR_CORE_DEFINES_SVH
`define KEY_CLICK_EVENT_DETECTOR_CORE_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define KCED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define KCED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kced_pkg.sv =====
package kced_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int LEVEL_BITS   = 4;
  localparam int IDX_W        = 2;
  localparam int FLAG_W       = 7;
  localparam int TIMER_W      = 15;
  localparam int SCAN_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;
  localparam int ST_W         = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd3;

  localparam logic [TIMER_W-1:0] LONG_TIME_RST   = 15'd2000;
  localparam logic [TIMER_W-1:0] DOUBLE_TIME_RST = 15'd200;
  localparam logic [TIMER_W-1:0] REPEAT_TIME_RST = 15'd100;
  localparam logic [SCAN_W-1:0]  SCAN_PERIOD_RST = 8'd20;

  // request kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // flag bits
  localparam int F_HOLD   = 0;
  localparam int F_DOWN   = 1;
  localparam int F_UP     = 2;
  localparam int F_SINGLE = 3;
  localparam int F_DOUBLE = 4;
  localparam int F_LONG   = 5;
  localparam int F_REPEAT = 6;

  localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = 7'h01;

  // click machine states
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESSED  = 3'd1;
  localparam logic [ST_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [ST_W-1:0] ST_SECOND   = 3'd3;
  localparam logic [ST_W-1:0] ST_LONG     = 3'd4;

  typedef logic [FLAG_W-1:0] flags_t;

  typedef struct packed {
    logic              tick;
    logic              scan;
    logic              chk_sel;
    logic              down;
    logic [FLAG_W-1:0] mask;
  } lane_ctrl_t;

  typedef struct packed {
    logic [TIMER_W-1:0] long_time;
    logic [TIMER_W-1:0] dbl_time;
    logic [TIMER_W-1:0] rpt_time;
  } timing_cfg_t;

endpackage

// ===== src/kced_lane.sv =====
module kced_lane
  import kced_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lane_ctrl_t  ctrl,
  input  timing_cfg_t tcfg,
  output flags_t      flags_o,
  output flags_t      flags_nxt_o
);

  logic [TIMER_W-1:0] timer_r, timer_nxt, timer_dec;
  logic [ST_W-1:0]    state_r, state_nxt;
  logic               now_r, now_nxt;
  flags_t             flags_r, flags_nxt;
  logic               hit;

  assign hit = |(flags_r & ctrl.mask);

  always_comb begin
    timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;
    timer_nxt = timer_r;
    state_nxt = state_r;
    now_nxt   = now_r;
    flags_nxt = flags_r;
    if (ctrl.tick) begin
      timer_nxt = timer_dec;
      if (ctrl.scan) begin
        now_nxt = ctrl.down;
        flags_nxt[F_HOLD] = ctrl.down;
        if (ctrl.down && !now_r) flags_nxt[F_DOWN] = 1'b1;
        if (!ctrl.down && now_r) flags_nxt[F_UP] = 1'b1;
        unique case (state_r)
          ST_IDLE: begin
            if (ctrl.down) begin
              state_nxt = ST_PRESSED;
              timer_nxt = tcfg.long_time;
            end
          end
          ST_PRESSED: begin
            if (!ctrl.down) begin
              timer_nxt = tcfg.dbl_time;
              state_nxt = ST_RELEASED;
            end else if (timer_dec == '0) begin
              flags_nxt[F_LONG] = 1'b1;
              timer_nxt = tcfg.rpt_time;
              state_nxt = ST_LONG;
            end
          end
          ST_RELEASED: begin
            if (ctrl.down) begin
              flags_nxt[F_DOUBLE] = 1'b1;
              state_nxt = ST_SECOND;
            end else if (timer_dec == '0) begin
              flags_nxt[F_SINGLE] = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          ST_SECOND: begin
            if (!ctrl.down) state_nxt = ST_IDLE;
          end
          ST_LONG: begin
            if (!ctrl.down) begin
              state_nxt = ST_IDLE;
            end else if (timer_dec == '0) begin
              flags_nxt[F_REPEAT] = 1'b1;
              timer_nxt = tcfg.rpt_time;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end else if (ctrl.chk_sel && hit && (ctrl.mask != MASK_HOLD_ONLY)) begin
      flags_nxt = flags_r & ~ctrl.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      state_r <= ST_IDLE;
      now_r   <= 1'b0;
      flags_r <= '0;
    end else begin
      timer_r <= timer_nxt;
      state_r <= state_nxt;
      now_r   <= now_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign flags_o     = flags_r;
  assign flags_nxt_o = flags_nxt;

endmodule

// ===== src/kced_merge.sv =====
module kced_merge
  import kced_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
  input  flags_t             lane_flags     [NUM_KEYS],
  input  flags_t             lane_flags_nxt [NUM_KEYS],
  input  logic               func,
  input  logic [IDX_W-1:0]   key_index,
  input  logic [FLAG_W-1:0]  check_mask,
  output logic               hit,
  output logic [FLAG_W-1:0]  key_flags
);

  flags_t sel_cur, sel_nxt;

  // one-hot select over the lanes, out-of-range index selects nothing
  always_comb begin
    sel_cur = '0;
    sel_nxt = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(key_index) == k) begin
        sel_cur = sel_cur | lane_flags[k];
        sel_nxt = sel_nxt | lane_flags_nxt[k];
      end
    end
  end

  assign hit       = (func == FUNC_CHECK) && (|(sel_cur & check_mask));
  assign key_flags = (func == FUNC_CHECK) ? sel_cur : sel_nxt;

endmodule

// ===== src/key_click_event_detector_core.sv =====
// Click, double-click, long-press and repeat detector for up to NUM_KEYS active-low keys.
// A tick request (func 0) counts the per-key timers down and, every scan_period ticks,
// samples the key levels; a check request (func 1) tests one key's masked flags, clearing
// them on a hit unless the mask is hold-only. Each key has its own lane, so one request
// per cycle is sustained while in_stall is low. A two-entry output buffer registers the
// results and keeps requests flowing under out_stall; in_stall rises only when both
// entries are full. The user must write timing registers (cfg_we, cfg_index, cfg_wdata)
// only while no request is in flight; the block does not enforce this. Reset values are
// 2000, 200, 100 and 20 ticks. Keys above the four level bits always read as released.
`include "key_click_event_detector_core_defines.svh"

module key_click_event_detector_core
  import kced_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [LEVEL_BITS-1:0] in_key_levels,
  input  logic [IDX_W-1:0]      in_key_index,
  input  logic [FLAG_W-1:0]     in_check_mask,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [FLAG_W-1:0]     out_key_flags
);

  timing_cfg_t        tcfg_r;
  logic [SCAN_W-1:0]  scan_period_r;
  logic [SCAN_W-1:0]  scan_count_r, scan_count_nxt;

  logic               in_accept, tick, scan, out_take;
  logic               res_hit;
  logic [FLAG_W-1:0]  res_flags;

  flags_t             lane_flags     [NUM_KEYS];
  flags_t             lane_flags_nxt [NUM_KEYS];

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [FLAG_W-1:0]  out_flags_r, out_flags_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic               skid_hit_r, skid_hit_nxt;
  logic [FLAG_W-1:0]  skid_flags_r, skid_flags_nxt;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign tick      = in_accept && (in_func == FUNC_TICK);
  assign scan      = tick && (scan_count_r >= scan_period_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcfg_r.long_time <= LONG_TIME_RST;
      tcfg_r.dbl_time  <= DOUBLE_TIME_RST;
      tcfg_r.rpt_time  <= REPEAT_TIME_RST;
      scan_period_r    <= SCAN_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_TIME:   tcfg_r.long_time <= cfg_wdata[TIMER_W-1:0];
        REG_DOUBLE_TIME: tcfg_r.dbl_time  <= cfg_wdata[TIMER_W-1:0];
        REG_REPEAT_TIME: tcfg_r.rpt_time  <= cfg_wdata[TIMER_W-1:0];
        REG_SCAN_PERIOD: scan_period_r    <= cfg_wdata[SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  // scan counter
  always_comb begin
    scan_count_nxt = scan_count_r;
    if (tick) begin
      scan_count_nxt = scan ? SCAN_W'(1) : scan_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_count_r <= '0;
    end else begin
      scan_count_r <= scan_count_nxt;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    lane_ctrl_t ctrl;
    logic       down;

    if (k < LEVEL_BITS) begin : g_pin
      assign down = !in_key_levels[k];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    assign ctrl.tick    = tick;
    assign ctrl.scan    = scan;
    assign ctrl.chk_sel = in_accept && (in_func == FUNC_CHECK) && (32'(in_key_index) == k);
    assign ctrl.down    = down;
    assign ctrl.mask    = in_check_mask;

    kced_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .tcfg        (tcfg_r),
      .flags_o     (lane_flags[k]),
      .flags_nxt_o (lane_flags_nxt[k])
    );
  end

  kced_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .lane_flags     (lane_flags),
    .lane_flags_nxt (lane_flags_nxt),
    .func           (in_func),
    .key_index      (in_key_index),
    .check_mask     (in_check_mask),
    .hit            (res_hit),
    .key_flags      (res_flags)
  );

  // two-entry output buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_flags_nxt  = out_flags_r;
    skid_valid_nxt = skid_valid_r;
    skid_hit_nxt   = skid_hit_r;
    skid_flags_nxt = skid_flags_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_hit_nxt    = skid_hit_r;
        out_flags_nxt  = skid_flags_r;
        skid_valid_nxt = 1'b0;
      end else if (in_accept) begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = res_hit;
        out_flags_nxt = res_flags;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_accept) begin
      skid_valid_nxt = 1'b1;
      skid_hit_nxt   = res_hit;
      skid_flags_nxt = res_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r    <= out_hit_nxt;
    out_flags_r  <= out_flags_nxt;
    skid_hit_r   <= skid_hit_nxt;
    skid_flags_r <= skid_flags_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_key_flags = out_flags_r;

  `KCED_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `KCED_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, out_valid_r && !skid_valid_r,
                    "skid entry not moved to output")
  `KCED_ASSERT_NEXT(a_skid_fills, out_valid_r && out_stall && in_accept, skid_valid_r,
                    "request lost while output stalled")
  `KCED_ASSERT_NEXT(a_tick_no_hit, in_accept && (in_func == FUNC_TICK) && !out_valid_r,
                    out_valid_r && !out_hit_r, "tick request reported a hit")

endmodule
